// ===== hw/rtl/shbm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the stable-hold baseline monitor: sizes, hold mode codes,
// register addresses and the request/response types of the window divider.
// No dependencies.
package shbm_pkg;

    localparam int PIXEL_COUNT = 256;
    localparam int ADDR_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int POS_W       = $clog2(PIXEL_COUNT + 1);

    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 32;
    localparam int CFG_W    = 16;
    localparam int MODE_W   = 2;
    localparam int WIN_W    = 13;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [WIN_W-1:0] WINDOW_MS    = 13'd5000;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 13'd312;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd16;

    localparam logic [MODE_W-1:0] MODE_IDLE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CAPTURING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SETTLED   = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_INTERVAL  = 3'd4;

    typedef struct packed {
        logic             start;
        logic [CFG_W-1:0] divisor;
    } shbm_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [WIN_W-1:0] quotient;
    } shbm_div_rsp_t;

endpackage

// ===== hw/rtl/shbm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pixel stream and the frame results.
// Depends on shbm_pkg for the field widths.
interface shbm_in_if import shbm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] raw_sample;
    logic                frame_last;
    logic                restart_hold;
    logic [FRAME_W-1:0]  frame_number;

    modport source (output valid, raw_sample, frame_last, restart_hold, frame_number,
                    input ready);
    modport sink   (input valid, raw_sample, frame_last, restart_hold, frame_number,
                    output ready);
endinterface

interface shbm_out_if import shbm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              capture_taken;
    logic              settled_action;
    logic [MODE_W-1:0] hold_state;
    logic              change_seen;

    modport source (output valid, capture_taken, settled_action, hold_state, change_seen,
                    input ready);
    modport sink   (input valid, capture_taken, settled_action, hold_state, change_seen,
                    output ready);
endinterface

// ===== hw/rtl/shbm_ram.sv =====
`timescale 1ns / 1ps
// One bank of the reference grid: single write port, single registered read port.
// Depends on shbm_pkg for depth and width.
module shbm_ram
    import shbm_pkg::*;
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [PIXEL_COUNT];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/shbm_window_div.sv =====
`timescale 1ns / 1ps
// Restoring divider that works out 5000 / max(interval, 1), one quotient bit
// per cycle. Depends on shbm_pkg for the request and response types.
module shbm_window_div
    import shbm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  shbm_div_req_t req,
    output shbm_div_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [CFG_W-1:0]    rem_reg, rem_next;
    logic [CFG_W-1:0]    div_reg, div_next;
    logic [WIN_W-1:0]    quo_reg, quo_next;
    logic [CFG_W:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, WINDOW_MS[cnt_reg]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'(WIN_W - 1);
            rem_next  = '0;
            quo_next  = '0;
            div_next  = (req.divisor == '0) ? CFG_W'(1) : req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CFG_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[WIN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CFG_W-1:0];
                quo_next = {quo_reg[WIN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/stable_hold_baseline_monitor_core.sv =====
`timescale 1ns / 1ps
// Stable-hold baseline monitor, top level. One pixel per cycle unless the window
// divider is busy or a last pixel waits on a full output register. The result of
// a frame passes the read stage, then the compare and decide stage, into an
// output register. Throughput is set by the per-bank reference RAM read port.
// After an interval register write no pixel is taken while the window divider runs.
// Reset is asynchronous, active low; the reference grid itself is not cleared.
module stable_hold_baseline_monitor_core
    import shbm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    shbm_in_if.sink            pixels,
    shbm_out_if.source         results
);

    logic [CFG_W-1:0]    threshold_reg, interval_reg;
    logic [WIN_W-1:0]    window_reg;
    shbm_div_req_t       div_req;
    shbm_div_rsp_t       div_rsp;
    logic                cfg_wr;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                bank_reg, bank_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [FRAME_W-1:0]  cap_reg, cap_next;
    logic                acc_reg, acc_next;

    logic                s2_valid_reg;
    logic [SAMPLE_W-1:0] s2_sample_reg;
    logic                s2_last_reg, s2_restart_reg, s2_inrange_reg;
    logic [FRAME_W-1:0]  s2_fnum_reg;
    logic [ADDR_W-1:0]   s2_pos_reg;
    logic                fwd0_reg, fwd1_reg;
    logic [SAMPLE_W-1:0] fwd_data_reg;

    logic                out_valid_reg;
    logic                out_capture_reg, out_action_reg, out_change_reg;
    logic [MODE_W-1:0]   out_mode_reg;

    logic                in_fire, s2_fire, wr_en, inrange;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] rd0, rd1, ref0, ref1, ref_val, diff, thr;
    logic                pix_changed, acc_eff;
    logic [MODE_W-1:0]   mode_a;
    logic [FRAME_W-1:0]  cap_base, elapsed;
    logic                win_hit, capture, action, changed;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr)
            ADDR_THRESHOLD: prdata = PDATA_W'(threshold_reg);
            ADDR_INTERVAL:  prdata = PDATA_W'(interval_reg);
            default:        prdata = '0;
        endcase
    end

    assign div_req.start   = cfg_wr && (paddr == ADDR_INTERVAL);
    assign div_req.divisor = pwdata[CFG_W-1:0];

    shbm_window_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            interval_reg  <= INTERVAL_RESET;
            window_reg    <= WINDOW_RESET;
        end
        else
        begin
            if (cfg_wr && (paddr == ADDR_THRESHOLD))
            begin
                threshold_reg <= pwdata[CFG_W-1:0];
            end
            if (div_req.start)
            begin
                interval_reg <= pwdata[CFG_W-1:0];
            end
            if (div_rsp.done)
            begin
                window_reg <= (div_rsp.quotient == '0) ? WIN_W'(1) : div_rsp.quotient;
            end
        end
    end

    // Handshakes. The compare stage stalls only when it holds a last pixel and the
    // output register is still full.
    assign s2_fire = s2_valid_reg &&
                     (!s2_last_reg || !out_valid_reg || results.ready);
    assign pixels.ready = (!s2_valid_reg || s2_fire) && !div_rsp.busy;
    assign in_fire = pixels.valid && pixels.ready;

    // Read stage: both banks are read at the pixel position; the active bank is
    // chosen in the compare stage, after any bank swap of the previous frame.
    assign inrange = (pos_reg < POS_W'(PIXEL_COUNT));
    assign rd_addr = pos_reg[ADDR_W-1:0];
    assign wr_en   = s2_fire && s2_inrange_reg;

    shbm_ram u_bank0 (
        .clk     (clk),
        .wr_en   (wr_en && bank_reg),
        .wr_addr (s2_pos_reg),
        .wr_data (s2_sample_reg),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (rd0)
    );

    shbm_ram u_bank1 (
        .clk     (clk),
        .wr_en   (wr_en && !bank_reg),
        .wr_addr (s2_pos_reg),
        .wr_data (s2_sample_reg),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (rd1)
    );

    always_comb
    begin
        pos_next = pos_reg;
        if (in_fire)
        begin
            if (pixels.frame_last)
            begin
                pos_next = '0;
            end
            else if (inrange)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (in_fire)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // A write retiring in the same cycle as the read lands too late for the RAM
    // output, so it is forwarded.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s2_sample_reg  <= pixels.raw_sample;
            s2_last_reg    <= pixels.frame_last;
            s2_restart_reg <= pixels.restart_hold;
            s2_fnum_reg    <= pixels.frame_number;
            s2_pos_reg     <= rd_addr;
            s2_inrange_reg <= inrange;
            fwd0_reg       <= wr_en && bank_reg && (s2_pos_reg == rd_addr);
            fwd1_reg       <= wr_en && !bank_reg && (s2_pos_reg == rd_addr);
            fwd_data_reg   <= s2_sample_reg;
        end
    end

    // Compare and frame decision stage.
    assign ref0    = fwd0_reg ? fwd_data_reg : rd0;
    assign ref1    = fwd1_reg ? fwd_data_reg : rd1;
    assign ref_val = bank_reg ? ref1 : ref0;
    assign diff    = (s2_sample_reg > ref_val) ? (s2_sample_reg - ref_val)
                                               : (ref_val - s2_sample_reg);
    assign thr     = (threshold_reg[CFG_W-1:1] == '0) ? SAMPLE_W'(1)
                                                      : SAMPLE_W'(threshold_reg[CFG_W-1:1]);
    assign pix_changed = s2_inrange_reg && (diff > thr);
    assign acc_eff     = acc_reg || pix_changed;

    assign mode_a   = s2_restart_reg ? MODE_IDLE : mode_reg;
    assign cap_base = s2_restart_reg ? '0 : cap_reg;
    assign changed  = (mode_a != MODE_IDLE) && acc_eff;
    assign elapsed  = s2_fnum_reg - cap_base;
    assign win_hit  = (elapsed >= FRAME_W'(window_reg));

    always_comb
    begin
        capture   = 1'b0;
        action    = 1'b0;
        mode_next = changed ? MODE_IDLE : mode_a;
        case (mode_next)
            MODE_CAPTURING:
            begin
                if (win_hit)
                begin
                    mode_next = MODE_SETTLED;
                    capture   = 1'b1;
                end
            end
            MODE_SETTLED:
            begin
                if (win_hit)
                begin
                    capture = 1'b1;
                    action  = 1'b1;
                end
            end
            MODE_IDLE:
            begin
                mode_next = MODE_CAPTURING;
                capture   = 1'b1;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
        cap_next  = capture ? s2_fnum_reg : cap_base;
        bank_next = capture ? !bank_reg : bank_reg;
        acc_next  = acc_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg      <= 1'b0;
            mode_reg      <= MODE_IDLE;
            cap_reg       <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_fire && s2_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s2_fire)
            begin
                if (s2_last_reg)
                begin
                    bank_reg <= bank_next;
                    mode_reg <= mode_next;
                    cap_reg  <= cap_next;
                    acc_reg  <= 1'b0;
                end
                else
                begin
                    acc_reg <= acc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire && s2_last_reg)
        begin
            out_capture_reg <= capture;
            out_action_reg  <= action;
            out_mode_reg    <= mode_next;
            out_change_reg  <= changed;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.capture_taken  = out_capture_reg;
    assign results.settled_action = out_action_reg;
    assign results.hold_state     = out_mode_reg;
    assign results.change_seen    = out_change_reg;

endmodule
